[rtl/core/gwwl_pkg.sv]
// ----------------------------------------------------------------------------
// Greedy word wrap package
// Types, register indexes and sizing constants shared by the line breaker
// and its checker.
// ----------------------------------------------------------------------------
package gwwl_pkg;

	// Fixed field widths of the interface.
	localparam int unsigned CHAR_W      = 16;
	localparam int unsigned ADV_W       = 16;
	localparam int unsigned LINE_W      = 24;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned SPACE_W     = 16;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned CFG_INDEX_W = 2;

	// Default parameter values.
	localparam int unsigned FRACTION_BITS_DEF = 6;
	localparam int unsigned WIDTH_BITS_DEF    = 24;

	// Result queue sizing: one character raises at most three records.
	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned RES_DEPTH   = 4;
	localparam int unsigned RES_PTR_W   = 2;
	localparam int unsigned RES_CNT_W   = 3;

	// Character codes with a meaning of their own.
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 16'h0020;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 16'h000A;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPACE_WIDTH    = 2'd0,
		REG_MAX_LINE_WIDTH = 2'd1,
		REG_MAX_LINE_COUNT = 2'd2
	} cfg_reg_t;

	// Record kinds.
	typedef enum logic {
		KIND_LINE    = 1'b0,
		KIND_SUMMARY = 1'b1
	} rec_kind_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic [ADV_W-1:0]  advance;
		logic              last_char;
	} char_item_t;

	typedef struct packed {
		rec_kind_t          record_kind;
		logic [LINE_W-1:0]  line_width;
		logic [COUNT_W-1:0] line_chars;
		logic               last_result;
	} rec_item_t;

endpackage

[rtl/core/greedy_word_wrap_line_breaker.sv]
// ----------------------------------------------------------------------------
// Greedy word wrap line breaker
// Streams UTF-16 characters with fixed-point advances and emits line records
// and a closing summary for each string.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                           Direction  Carries
//  --------  --------------------------------  ---------  -----------------------
//  char      char_valid / char_ready / item    in         one character request
//  rec       rec_valid / rec_ready / item      out        one line or summary
//  cfg       cfg_we / cfg_index / cfg_wdata    in         register write
//
// One character is taken per clock while char_ready is high. All state updates
// happen in the cycle the request is accepted; the records it raises (none to
// three) are written into a four-entry result queue, which drains one record per
// clock of rec_ready. char_ready is high whenever the queue holds at most one
// record, so a stream of characters raising at most one record each runs at full
// rate. Reset is asynchronous and returns registers to their documented defaults.
// A stalled output only holds the input off once two records are waiting.
//
module greedy_word_wrap_line_breaker #(
	parameter int unsigned FRACTION_BITS = gwwl_pkg::FRACTION_BITS_DEF,
	parameter int unsigned WIDTH_BITS    = gwwl_pkg::WIDTH_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                char_valid,
	output logic                                char_ready,
	input  gwwl_pkg::char_item_t                char_item,
	output logic                                rec_valid,
	input  logic                                rec_ready,
	output gwwl_pkg::rec_item_t                 rec_item,
	input  logic                                cfg_we,
	input  logic [gwwl_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gwwl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int unsigned WB     = WIDTH_BITS;
	localparam int unsigned LW     = gwwl_pkg::LINE_W;
	localparam int unsigned CW     = gwwl_pkg::COUNT_W;
	// Width in which line widths and the 24-bit limit are compared.
	localparam int unsigned EXT_W  = (WB > LW) ? WB : LW;
	localparam logic [WB-1:0] WIDTH_SAT = {WB{1'b1}};
	localparam logic [gwwl_pkg::SPACE_W-1:0] SPACE_RESET =
		gwwl_pkg::SPACE_W'(4 << FRACTION_BITS);
	localparam int unsigned READY_LIMIT = gwwl_pkg::RES_DEPTH - gwwl_pkg::MAX_RESULTS;

	// Configuration registers.
	logic [gwwl_pkg::SPACE_W-1:0] space_width_q;
	logic [LW-1:0]                max_line_width_q;
	logic [CW-1:0]                max_line_count_q;

	// Per-string state.
	logic [WB-1:0] current_width_q;
	logic [WB-1:0] word_width_q;
	logic [WB-1:0] widest_line_q;
	logic [CW-1:0] char_position_q;
	logic [CW-1:0] line_start_q;
	logic [CW-1:0] word_start_q;
	logic [CW-1:0] chars_on_line_q;
	logic [CW-1:0] lines_so_far_q;
	logic [gwwl_pkg::CHAR_W-1:0] previous_char_q;

	// Result queue.
	gwwl_pkg::rec_item_t                res_mem [gwwl_pkg::RES_DEPTH];
	logic [gwwl_pkg::RES_PTR_W-1:0]     wr_ptr_q;
	logic [gwwl_pkg::RES_PTR_W-1:0]     rd_ptr_q;
	logic [gwwl_pkg::RES_CNT_W-1:0]     count_q;

	logic accept;
	logic pop;

	// Character step signals.
	logic [gwwl_pkg::CHAR_W-1:0] c;
	logic [WB-1:0]               size;
	logic                        is_newline;
	logic                        prev_is_space;
	logic                        cur_is_graph;
	logic                        word_begin;
	logic [CW-1:0]               word_start;
	logic [WB-1:0]               word_base;
	logic [WB:0]                 cw_sum;
	logic [WB:0]                 ww_sum;
	logic [WB-1:0]               cw1;
	logic [WB-1:0]               ww1;
	logic [CW-1:0]               inc_chars;
	logic                        multi;
	logic                        exceeds;
	logic                        can_break;
	logic                        brk_line;
	logic                        brk_word;
	logic                        broke;
	logic [CW-1:0]               next_chars;
	logic [WB-1:0]               kept;
	logic [WB-1:0]               brk_width;
	logic [CW-1:0]               brk_chars;
	logic [WB-1:0]               widest1;
	logic [WB-1:0]               cw2;
	logic [CW-1:0]               chars2;
	logic [CW-1:0]               lines2;
	logic [WB-1:0]               widest3;
	logic                        emit_final;
	logic                        emit_summary;
	logic [EXT_W-1:0]            ext_cw1;
	logic [EXT_W-1:0]            ext_limit;
	logic [EXT_W-1:0]            ext_brk;
	logic [EXT_W-1:0]            ext_cw2;
	logic [EXT_W-1:0]            ext_widest;

	gwwl_pkg::rec_item_t rec_brk;
	gwwl_pkg::rec_item_t rec_final;
	gwwl_pkg::rec_item_t rec_summary;
	logic [gwwl_pkg::RES_PTR_W-1:0] ptr_final;
	logic [gwwl_pkg::RES_PTR_W-1:0] ptr_summary;
	logic [1:0]                     push_count;

	assign accept     = char_valid && char_ready;
	assign pop        = rec_valid && rec_ready;
	assign char_ready = (count_q <= gwwl_pkg::RES_CNT_W'(READY_LIMIT));
	assign rec_valid  = (count_q != '0);
	assign rec_item   = res_mem[rd_ptr_q];

	// ---------------------------------------------------------------------
	// Character step: the whole per-character update in one pass.
	// ---------------------------------------------------------------------
	always_comb begin
		c          = char_item.char_code;
		is_newline = (c == gwwl_pkg::CHAR_NEWLINE);
		if (c == gwwl_pkg::CHAR_SPACE) begin
			size = WB'(space_width_q);
		end else if (is_newline) begin
			size = '0;
		end else begin
			size = WB'(char_item.advance);
		end

		// Word boundaries use ASCII classes only.
		cur_is_graph  = (c >= 16'h0021) && (c <= 16'h007E);
		prev_is_space = (previous_char_q == gwwl_pkg::CHAR_SPACE) ||
		                ((previous_char_q >= 16'h0009) && (previous_char_q <= 16'h000D));
		word_begin    = cur_is_graph && prev_is_space;
		word_start    = word_begin ? char_position_q : word_start_q;
		word_base     = word_begin ? '0 : word_width_q;

		// Saturating width sums.
		cw_sum = {1'b0, current_width_q} + {1'b0, size};
		ww_sum = {1'b0, word_base} + {1'b0, size};
		cw1    = cw_sum[WB] ? WIDTH_SAT : cw_sum[WB-1:0];
		ww1    = ww_sum[WB] ? WIDTH_SAT : ww_sum[WB-1:0];

		inc_chars = chars_on_line_q + CW'(1);
		multi     = (word_start != line_start_q);
		ext_cw1   = EXT_W'(cw1);
		ext_limit = EXT_W'(max_line_width_q);
		exceeds   = (ext_cw1 > ext_limit);
		can_break = (lines_so_far_q < max_line_count_q);

		// A newline or a lone overlong word breaks after this character;
		// an overflow with several words breaks before the current word.
		brk_line = can_break && (is_newline || (exceeds && !multi));
		brk_word = can_break && !brk_line && exceeds && multi;
		broke    = brk_line || brk_word;

		next_chars = (char_position_q - word_start) + CW'(1);
		kept       = (cw1 > ww1) ? (cw1 - ww1) : '0;
		brk_width  = brk_line ? cw1 : kept;
		brk_chars  = brk_line ? inc_chars : (inc_chars - next_chars);
		widest1    = (broke && (brk_width > widest_line_q)) ? brk_width : widest_line_q;

		if (brk_line) begin
			cw2    = '0;
			chars2 = '0;
		end else if (brk_word) begin
			cw2    = ww1;
			chars2 = next_chars;
		end else begin
			cw2    = cw1;
			chars2 = inc_chars;
		end
		lines2 = broke ? (lines_so_far_q + CW'(1)) : lines_so_far_q;

		widest3      = (cw2 > widest1) ? cw2 : widest1;
		emit_summary = char_item.last_char;
		emit_final   = char_item.last_char && (lines2 > CW'(1));

		ext_brk    = EXT_W'(brk_width);
		ext_cw2    = EXT_W'(cw2);
		ext_widest = EXT_W'(widest3);

		rec_brk.record_kind     = gwwl_pkg::KIND_LINE;
		rec_brk.line_width      = ext_brk[LW-1:0];
		rec_brk.line_chars      = brk_chars;
		rec_brk.last_result     = !char_item.last_char;

		rec_final.record_kind   = gwwl_pkg::KIND_LINE;
		rec_final.line_width    = ext_cw2[LW-1:0];
		rec_final.line_chars    = chars2;
		rec_final.last_result   = 1'b0;

		rec_summary.record_kind = gwwl_pkg::KIND_SUMMARY;
		rec_summary.line_width  = ext_widest[LW-1:0];
		rec_summary.line_chars  = lines2;
		rec_summary.last_result = 1'b1;

		// Records are packed into consecutive queue slots.
		ptr_final   = wr_ptr_q + gwwl_pkg::RES_PTR_W'(broke);
		ptr_summary = ptr_final + gwwl_pkg::RES_PTR_W'(emit_final);
		push_count  = 2'(broke) + 2'(emit_final) + 2'(emit_summary);
	end

	// ---------------------------------------------------------------------
	// Configuration registers.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_width_q    <= SPACE_RESET;
			max_line_width_q <= {LW{1'b1}};
			max_line_count_q <= {CW{1'b1}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				gwwl_pkg::REG_SPACE_WIDTH:    space_width_q    <= cfg_wdata[gwwl_pkg::SPACE_W-1:0];
				gwwl_pkg::REG_MAX_LINE_WIDTH: max_line_width_q <= cfg_wdata[LW-1:0];
				gwwl_pkg::REG_MAX_LINE_COUNT: max_line_count_q <= cfg_wdata[CW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Per-string state. The last character of a string returns everything
	// to its reset value so that the next character opens a new string.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_width_q <= '0;
			word_width_q    <= '0;
			widest_line_q   <= '0;
			char_position_q <= '0;
			line_start_q    <= '0;
			word_start_q    <= '0;
			chars_on_line_q <= '0;
			lines_so_far_q  <= CW'(1);
			previous_char_q <= '0;
		end else if (accept) begin
			if (char_item.last_char) begin
				current_width_q <= '0;
				word_width_q    <= '0;
				widest_line_q   <= '0;
				char_position_q <= '0;
				line_start_q    <= '0;
				word_start_q    <= '0;
				chars_on_line_q <= '0;
				lines_so_far_q  <= CW'(1);
				previous_char_q <= '0;
			end else begin
				current_width_q <= cw2;
				widest_line_q   <= widest1;
				char_position_q <= char_position_q + CW'(1);
				chars_on_line_q <= chars2;
				lines_so_far_q  <= lines2;
				previous_char_q <= c;
				if (broke) begin
					line_start_q <= char_position_q + CW'(1);
					word_start_q <= char_position_q + CW'(1);
					word_width_q <= '0;
				end else begin
					word_start_q <= word_start;
					word_width_q <= ww1;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result queue.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		for (int i = 0; i < gwwl_pkg::RES_DEPTH; i++) begin
			if (accept) begin
				if (broke && (wr_ptr_q == gwwl_pkg::RES_PTR_W'(i))) begin
					res_mem[i] <= rec_brk;
				end
				if (emit_final && (ptr_final == gwwl_pkg::RES_PTR_W'(i))) begin
					res_mem[i] <= rec_final;
				end
				if (emit_summary && (ptr_summary == gwwl_pkg::RES_PTR_W'(i))) begin
					res_mem[i] <= rec_summary;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + gwwl_pkg::RES_PTR_W'(push_count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gwwl_pkg::RES_PTR_W'(1);
			end
			count_q <= count_q
			         + (accept ? gwwl_pkg::RES_CNT_W'(push_count) : '0)
			         - gwwl_pkg::RES_CNT_W'(pop);
		end
	end

endmodule

[rtl/core/gwwl_checker.sv]
// ----------------------------------------------------------------------------
// Greedy word wrap checker
// Port-level assertions for the line breaker, attached by bind.
// ----------------------------------------------------------------------------
module gwwl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             char_ready,
	input logic                             rec_valid,
	input logic                             rec_ready,
	input gwwl_pkg::rec_item_t              rec_item
);

	// A waiting record stays put until it is taken.
	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid && $stable(rec_item))
		else $error("record changed while stalled");

	// Input is only held off while records are waiting.
	a_ready_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!char_ready |-> rec_valid)
		else $error("input stalled with no pending record");

	// A summary always closes the records of its character and counts a line.
	a_summary_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && (rec_item.record_kind == gwwl_pkg::KIND_SUMMARY) |->
		rec_item.last_result && (rec_item.line_chars != '0))
		else $error("malformed summary record");

	// Records of one character are queued together, so a record that is not
	// the last of its group is always followed straight away by another.
	a_group_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready && !rec_item.last_result |=> rec_valid)
		else $error("gap inside a group of records");

endmodule

bind greedy_word_wrap_line_breaker gwwl_checker u_gwwl_checker (.*);
